// ===== rtl/ring_queue_with_key_search_macros.svh =====
// Assertion macros for the ring queue with key search.
// Used by the top level only; no other dependencies.
`ifndef RING_QUEUE_WITH_KEY_SEARCH_MACROS_SVH
`define RING_QUEUE_WITH_KEY_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RQKS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rqks assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RQKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rqks assertion failed");

`endif

// ===== rtl/rqks_pkg.sv =====
// Shared types and codes for the ring queue with key search.
// No dependencies; used by rqks_cell and ring_queue_with_key_search.
`default_nettype none

package rqks_pkg;

   localparam int KEY_W    = 37;
   localparam int AMOUNT_W = 32;
   localparam int KIND_W   = 8;
   localparam int COUNT_W  = 5;

   // One stored transaction record
   typedef struct packed {
      logic [KEY_W-1:0]           key;
      logic [KEY_W-1:0]           dest_key;
      logic signed [AMOUNT_W-1:0] amount;
      logic [KIND_W-1:0]          kind;
   } rec_type;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_FRONT  = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // Command that every cell of the chain carries out
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP,
      CELL_ROT
   } cell_cmd_type;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/rqks_cell.sv =====
// One slot of the record chain: holds a record, loads a pushed one as first
// free slot, takes the right neighbor's on pop or rotate. Depends on rqks_pkg.
`default_nettype none

module rqks_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  wire logic                  clock,
   input  wire rqks_pkg::cell_cmd_type cmd,
   input  wire logic [CW-1:0]         count,
   input  wire rqks_pkg::rec_type     right_rec,
   input  wire rqks_pkg::rec_type     head_rec,
   input  wire rqks_pkg::rec_type     push_rec,
   output rqks_pkg::rec_type          rec
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   rqks_pkg::rec_type rec_ff;
   rqks_pkg::rec_type rec_in;

   // Select the next record for this slot
   always_comb begin
      rec_in = rec_ff;
      unique case (cmd)
         rqks_pkg::CELL_HOLD: rec_in = rec_ff;
         // load only at the first free slot
         rqks_pkg::CELL_PUSH: begin
            if (IDX == count) begin
               rec_in = push_rec;
            end
         end
         rqks_pkg::CELL_POP: rec_in = right_rec;
         // last occupied slot takes the head, the rest advance
         rqks_pkg::CELL_ROT: begin
            if (IDX + CW'(1) == count) begin
               rec_in = head_rec;
            end else begin
               rec_in = right_rec;
            end
         end
         default: rec_in = rec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

`default_nettype wire

// ===== rtl/ring_queue_with_key_search.sv =====
// Ring queue of transaction records with search by key.
// Depends on rqks_pkg, rqks_cell and ring_queue_with_key_search_macros.svh.
//
// Usage:
//   req_* carries one operation word (push, pop, front, search); it is taken
//   at an edge where req_valid is high and req_stall is low. rsp_* returns one
//   result word per operation, taken where rsp_valid is high and rsp_stall low.
//   csr_* writes the capacity (0 acts as 1, above DEPTH acts as DEPTH); a
//   write empties the queue. csr_ready is high while no search is running.
// Timing:
//   Push, pop and front are registered at the accepting edge: the result shows
//   the next cycle; a new word can follow every cycle if rsp_stall is low.
//   Search rotates the chain once through the head cell, one slot a cycle, and
//   accepts no new word until its result is registered.
// Reset: synchronous, active high; queue empty, capacity DEPTH, no result.
// Stall: a result held by rsp_stall stays in the output register; a new word
//   is accepted in that cycle only if the held one is taken at the same edge.
`default_nettype none

module ring_queue_with_key_search #(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_opcode,
   input  wire logic [36:0]              req_key,
   input  wire logic [36:0]              req_dest_key,
   input  wire logic signed [31:0]       req_amount,
   input  wire logic [7:0]               req_transaction_kind,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [36:0]                   rsp_out_key,
   output logic [36:0]                   rsp_out_dest_key,
   output logic signed [31:0]            rsp_out_amount,
   output logic [7:0]                    rsp_out_kind,
   output logic [4:0]                    rsp_count,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [4:0]               csr_wdata
);

`include "ring_queue_with_key_search_macros.svh"

   localparam int CW = $clog2(DEPTH + 1);

   typedef logic [CW-1:0] cnt_type;

   rqks_pkg::state_type    state_ff, state_in;
   cnt_type                cap_ff, cap_in;
   cnt_type                count_ff, count_in;
   cnt_type                scan_ff, scan_in;
   logic [36:0]            skey_ff, skey_in;
   logic                   found_ff, found_in;
   rqks_pkg::rec_type      frec_ff, frec_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rqks_pkg::status_type   rsp_status_ff, rsp_status_in;
   rqks_pkg::rec_type      rsp_rec_ff, rsp_rec_in;
   logic [4:0]             rsp_count_ff, rsp_count_in;

   rqks_pkg::cell_cmd_type cell_cmd;
   rqks_pkg::rec_type      push_rec;
   rqks_pkg::rec_type      cell_rec [DEPTH];

   logic out_free;
   logic req_accept;
   logic csr_write;

   // Handshakes
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != rqks_pkg::S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == rqks_pkg::S_IDLE);
   assign csr_write  = csr_valid && csr_ready;

   assign push_rec.key      = req_key;
   assign push_rec.dest_key = req_dest_key;
   assign push_rec.amount   = req_amount;
   assign push_rec.kind     = req_transaction_kind;

   // Chain of record cells, head at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rqks_pkg::rec_type right_rec;
      if (i == DEPTH - 1) begin : g_last
         assign right_rec = push_rec;
      end else begin : g_mid
         assign right_rec = cell_rec[i+1];
      end
      rqks_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock     (clock),
         .cmd       (cell_cmd),
         .count     (count_ff),
         .right_rec (right_rec),
         .head_rec  (cell_rec[0]),
         .push_rec  (push_rec),
         .rec       (cell_rec[i])
      );
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rqks_pkg::S_IDLE: begin
            if (req_accept && rqks_pkg::op_type'(req_opcode) == rqks_pkg::OP_SEARCH) begin
               state_in = rqks_pkg::S_SCAN;
            end
         end
         rqks_pkg::S_SCAN: begin
            if (scan_ff == count_ff && out_free) begin
               state_in = rqks_pkg::S_IDLE;
            end
         end
         default: state_in = rqks_pkg::S_IDLE;
      endcase
   end

   // Datapath and cell commands
   always_comb begin
      int cap_val;
      cap_val       = int'(csr_wdata);
      cap_in        = cap_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      skey_in       = skey_ff;
      found_in      = found_ff;
      frec_in       = frec_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_count_in  = rsp_count_ff;
      cell_cmd      = rqks_pkg::CELL_HOLD;

      unique case (state_ff)
         rqks_pkg::S_IDLE: begin
            if (req_accept) begin
               rsp_rec_in = '0;
               unique case (rqks_pkg::op_type'(req_opcode))
                  rqks_pkg::OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= cap_ff) begin
                        rsp_status_in = rqks_pkg::STAT_FULL;
                        rsp_count_in  = 5'(count_ff);
                     end else begin
                        cell_cmd      = rqks_pkg::CELL_PUSH;
                        count_in      = count_ff + CW'(1);
                        rsp_status_in = rqks_pkg::STAT_OK;
                        rsp_count_in  = 5'(count_ff + CW'(1));
                     end
                  end
                  rqks_pkg::OP_POP: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = rqks_pkg::STAT_EMPTY;
                        rsp_count_in  = 5'(count_ff);
                     end else begin
                        cell_cmd      = rqks_pkg::CELL_POP;
                        count_in      = count_ff - CW'(1);
                        rsp_status_in = rqks_pkg::STAT_OK;
                        rsp_rec_in    = cell_rec[0];
                        rsp_count_in  = 5'(count_ff - CW'(1));
                     end
                  end
                  rqks_pkg::OP_FRONT: begin
                     rsp_valid_in = 1'b1;
                     rsp_count_in = 5'(count_ff);
                     if (count_ff == '0) begin
                        rsp_status_in = rqks_pkg::STAT_EMPTY;
                     end else begin
                        rsp_status_in = rqks_pkg::STAT_OK;
                        rsp_rec_in    = cell_rec[0];
                     end
                  end
                  rqks_pkg::OP_SEARCH: begin
                     rsp_rec_in = rsp_rec_ff;
                     skey_in    = req_key;
                     found_in   = 1'b0;
                     frec_in    = '0;
                     scan_in    = '0;
                  end
                  default: rsp_rec_in = '0;
               endcase
            end
         end
         rqks_pkg::S_SCAN: begin
            if (scan_ff != count_ff) begin
               // compare the head, then rotate it to the back
               cell_cmd = rqks_pkg::CELL_ROT;
               scan_in  = scan_ff + CW'(1);
               if (!found_ff && cell_rec[0].key == skey_ff) begin
                  found_in = 1'b1;
                  frec_in  = cell_rec[0];
               end
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_ff ? rqks_pkg::STAT_OK : rqks_pkg::STAT_NOT_FOUND;
               rsp_rec_in    = found_ff ? frec_ff : '0;
               rsp_count_in  = 5'(count_ff);
            end
         end
         default: cell_cmd = rqks_pkg::CELL_HOLD;
      endcase

      // Capacity write: clamp and empty the queue
      if (csr_write) begin
         if (cap_val == 0) begin
            cap_val = 1;
         end else if (cap_val > DEPTH) begin
            cap_val = DEPTH;
         end
         cap_in   = CW'(cap_val);
         count_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqks_pkg::S_IDLE;
         cap_ff       <= CW'(DEPTH);
         count_ff     <= '0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      skey_ff       <= skey_in;
      frec_ff       <= frec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_key      = rsp_rec_ff.key;
   assign rsp_out_dest_key = rsp_rec_ff.dest_key;
   assign rsp_out_amount   = rsp_rec_ff.amount;
   assign rsp_out_kind     = rsp_rec_ff.kind;
   assign rsp_count        = rsp_count_ff;

   // Checks
   `RQKS_ASSERT_NOW(a_count_within_cap, clock, reset, 1'b1, count_ff <= cap_ff)
   `RQKS_ASSERT_NOW(a_scan_blocks_req, clock, reset, state_ff == rqks_pkg::S_SCAN, req_stall)
   `RQKS_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == rqks_pkg::S_SCAN, scan_ff <= count_ff)
   `RQKS_ASSERT_NEXT(a_scan_keeps_count, clock, reset, state_ff == rqks_pkg::S_SCAN, $stable(count_ff))

endmodule

`default_nettype wire

// ===== verif/ring_queue_with_key_search_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ring_queue_with_key_search: a directed table, then random
// push/pop/front/search words under random valid and stall gaps, checked against a queue model.
// Depends on rqks_pkg and the ring_queue_with_key_search RTL.

module ring_queue_with_key_search_tb;

   localparam int DEPTH = 16;
   localparam logic [36:0] KMAX = 37'd99999999999;
   localparam logic [36:0] K0 = 37'd0;
   localparam logic [36:0] KA = 37'h1555555555;
   localparam logic [36:0] KB = 37'h0AAAAAAAAA;
   localparam logic [31:0] AMIN = 32'h80000000;
   localparam logic [31:0] AMAX = 32'h7FFFFFFF;
   localparam int WORDS_PER_PHASE = 190;
   localparam int N_PHASES = 10;
   localparam int IDLE_PCT = 21;
   localparam int STALL_LIMIT = 3000;
   localparam int BACKLOG_AT = 600;
   localparam int BACKLOG_CYCLES = 300;
   localparam int QUIET_FROM = 1000;
   localparam int QUIET_TO = 1300;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      rqks_pkg::op_type  op;
      rqks_pkg::rec_type rec;
   } op_word_type;

   typedef struct packed {
      rqks_pkg::status_type status;
      rqks_pkg::rec_type    rec;
      logic [4:0]           count;
   } result_word_type;

   typedef struct packed {
      op_word_type     w;
      logic            pinned;
      result_word_type res;
   } sched_word_type;

   typedef enum logic {ROW_OP, ROW_CAP} row_kind_type;

   typedef struct packed {
      row_kind_type         what;
      logic [4:0]           cap;
      rqks_pkg::op_type     op;
      rqks_pkg::rec_type    give;
      logic                 pinned;
      rqks_pkg::status_type status;
      rqks_pkg::rec_type    take;
      logic [4:0]           count;
   } plan_row_type;

   localparam rqks_pkg::rec_type NO_REC = '0;

   // Directed words; pinned rows carry a hand-written result
   plan_row_type directed_plan [23] = '{
      '{ROW_OP, 5'd0, rqks_pkg::OP_POP, NO_REC, 1'b1, rqks_pkg::STAT_EMPTY, NO_REC, 5'd0},
      '{ROW_OP, 5'd0, rqks_pkg::OP_FRONT, NO_REC, 1'b1, rqks_pkg::STAT_EMPTY, NO_REC, 5'd0},
      '{ROW_OP, 5'd0, rqks_pkg::OP_SEARCH, '{KA, K0, 32'd0, 8'd0}, 1'b1,
        rqks_pkg::STAT_NOT_FOUND, NO_REC, 5'd0},
      '{ROW_OP, 5'd0, rqks_pkg::OP_PUSH, '{KMAX, K0, AMIN, 8'hFF}, 1'b1,
        rqks_pkg::STAT_OK, NO_REC, 5'd1},
      '{ROW_OP, 5'd0, rqks_pkg::OP_PUSH, '{K0, KMAX, AMAX, 8'h00}, 1'b1,
        rqks_pkg::STAT_OK, NO_REC, 5'd2},
      '{ROW_OP, 5'd0, rqks_pkg::OP_PUSH, '{KMAX, KA, 32'hFFFFFFFF, 8'hAA}, 1'b1,
        rqks_pkg::STAT_OK, NO_REC, 5'd3},
      '{ROW_OP, 5'd0, rqks_pkg::OP_PUSH, '{KA, KB, 32'h55555555, 8'h55}, 1'b1,
        rqks_pkg::STAT_OK, NO_REC, 5'd4},
      '{ROW_OP, 5'd0, rqks_pkg::OP_FRONT, NO_REC, 1'b1, rqks_pkg::STAT_OK,
        '{KMAX, K0, AMIN, 8'hFF}, 5'd4},
      '{ROW_OP, 5'd0, rqks_pkg::OP_SEARCH, '{KMAX, K0, 32'd0, 8'd0}, 1'b1, rqks_pkg::STAT_OK,
        '{KMAX, K0, AMIN, 8'hFF}, 5'd4},
      '{ROW_OP, 5'd0, rqks_pkg::OP_SEARCH, NO_REC, 1'b1, rqks_pkg::STAT_OK,
        '{K0, KMAX, AMAX, 8'h00}, 5'd4},
      '{ROW_OP, 5'd0, rqks_pkg::OP_SEARCH, '{KB, K0, 32'd0, 8'd0}, 1'b1,
        rqks_pkg::STAT_NOT_FOUND, NO_REC, 5'd4},
      '{ROW_OP, 5'd0, rqks_pkg::OP_POP, NO_REC, 1'b1, rqks_pkg::STAT_OK,
        '{KMAX, K0, AMIN, 8'hFF}, 5'd3},
      '{ROW_OP, 5'd0, rqks_pkg::OP_SEARCH, '{KMAX, K0, 32'd0, 8'd0}, 1'b1, rqks_pkg::STAT_OK,
        '{KMAX, KA, 32'hFFFFFFFF, 8'hAA}, 5'd3},
      '{ROW_OP, 5'd0, rqks_pkg::OP_SEARCH, '{KA, K0, 32'd0, 8'd0}, 1'b1, rqks_pkg::STAT_OK,
        '{KA, KB, 32'h55555555, 8'h55}, 5'd3},
      // capacity 0 acts as 1 and the write empties the queue
      '{ROW_CAP, 5'd0, rqks_pkg::OP_PUSH, NO_REC, 1'b0, rqks_pkg::STAT_OK, NO_REC, 5'd0},
      '{ROW_OP, 5'd0, rqks_pkg::OP_FRONT, NO_REC, 1'b1, rqks_pkg::STAT_EMPTY, NO_REC, 5'd0},
      '{ROW_OP, 5'd0, rqks_pkg::OP_PUSH, '{KB, KA, 32'hAAAAAAAA, 8'h5A}, 1'b1,
        rqks_pkg::STAT_OK, NO_REC, 5'd1},
      '{ROW_OP, 5'd0, rqks_pkg::OP_PUSH, '{KA, KB, AMAX, 8'hC3}, 1'b1,
        rqks_pkg::STAT_FULL, NO_REC, 5'd1},
      '{ROW_OP, 5'd0, rqks_pkg::OP_SEARCH, '{KB, K0, 32'd0, 8'd0}, 1'b1, rqks_pkg::STAT_OK,
        '{KB, KA, 32'hAAAAAAAA, 8'h5A}, 5'd1},
      '{ROW_OP, 5'd0, rqks_pkg::OP_POP, NO_REC, 1'b1, rqks_pkg::STAT_OK,
        '{KB, KA, 32'hAAAAAAAA, 8'h5A}, 5'd0},
      '{ROW_OP, 5'd0, rqks_pkg::OP_PUSH, '{37'd7, 37'd9, 32'd1, 8'h01}, 1'b1,
        rqks_pkg::STAT_OK, NO_REC, 5'd1},
      '{ROW_OP, 5'd0, rqks_pkg::OP_POP, NO_REC, 1'b1, rqks_pkg::STAT_OK,
        '{37'd7, 37'd9, 32'd1, 8'h01}, 5'd0},
      '{ROW_OP, 5'd0, rqks_pkg::OP_SEARCH, '{37'd7, K0, 32'd0, 8'd0}, 1'b1,
        rqks_pkg::STAT_NOT_FOUND, NO_REC, 5'd0}
   };

   // Capacity of each random phase; the last ones are drawn at random
   logic [4:0] phase_caps [8] = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd5, 5'd10, 5'd3, 5'd17};

   logic clock;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_opcode = '0;
   logic [36:0] req_key = '0;
   logic [36:0] req_dest_key = '0;
   logic signed [31:0] req_amount = '0;
   logic [7:0] req_transaction_kind = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [36:0] rsp_out_key;
   logic [36:0] rsp_out_dest_key;
   logic signed [31:0] rsp_out_amount;
   logic [7:0] rsp_out_kind;
   logic [4:0] rsp_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_wdata = '0;

   // Queue model state
   rqks_pkg::rec_type slot_rec [DEPTH];
   int head_at = 0;
   int tail_at = 0;
   int held = 0;
   int cap_in_use = DEPTH;

   sched_word_type word_backlog [$];
   result_word_type pending_results [$];
   sched_word_type in_flight;
   result_word_type want;
   logic [36:0] recent_keys [$];
   logic [36:0] hot_keys [8];

   int words_taken = 0;
   int results_seen = 0;
   int mismatches = 0;
   int cap_writes = 0;
   int n_op [4] = '{0, 0, 0, 0};
   int n_full = 0;
   int n_empty = 0;
   int n_missed = 0;
   int backlog_left = 0;
   logic backlog_done = 1'b0;
   int stuck_cycles = 0;
   logic quiet;

   assign quiet = (words_taken >= QUIET_FROM) && (words_taken < QUIET_TO);

   ring_queue_with_key_search #(.DEPTH(DEPTH)) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_key              (req_key),
      .req_dest_key         (req_dest_key),
      .req_amount           (req_amount),
      .req_transaction_kind (req_transaction_kind),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_out_key          (rsp_out_key),
      .rsp_out_dest_key     (rsp_out_dest_key),
      .rsp_out_amount       (rsp_out_amount),
      .rsp_out_kind         (rsp_out_kind),
      .rsp_count            (rsp_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int wrap_slot(input int idx);
      return (idx + 1 >= cap_in_use) ? 0 : idx + 1;
   endfunction

   // Apply one word to the queue model and return the result it should give
   function automatic result_word_type next_queue_result(input op_word_type w);
      result_word_type r;
      int slot;
      int i;
      bit found;
      r.status = rqks_pkg::STAT_OK;
      r.rec = '0;
      case (w.op)
         rqks_pkg::OP_PUSH: begin
            if (held >= cap_in_use) begin
               r.status = rqks_pkg::STAT_FULL;
            end else begin
               slot_rec[tail_at] = w.rec;
               tail_at = wrap_slot(tail_at);
               held++;
            end
         end
         rqks_pkg::OP_POP: begin
            if (held == 0) begin
               r.status = rqks_pkg::STAT_EMPTY;
            end else begin
               r.rec = slot_rec[head_at];
               head_at = wrap_slot(head_at);
               held--;
            end
         end
         rqks_pkg::OP_FRONT: begin
            if (held == 0) r.status = rqks_pkg::STAT_EMPTY;
            else r.rec = slot_rec[head_at];
         end
         default: begin
            // oldest matching record wins
            found = 1'b0;
            slot = head_at;
            for (i = 0; i < held; i++) begin
               if (!found && slot_rec[slot].key == w.rec.key) begin
                  r.rec = slot_rec[slot];
                  found = 1'b1;
               end
               slot = wrap_slot(slot);
            end
            if (!found) r.status = rqks_pkg::STAT_NOT_FOUND;
         end
      endcase
      r.count = 5'(held);
      return r;
   endfunction

   function automatic logic [36:0] random_key();
      logic [63:0] k;
      k = {$urandom, $urandom} & 64'h1F_FFFF_FFFF;
      if (k > 64'(KMAX)) k = k - 64'(KMAX) - 64'd1;
      return k[36:0];
   endfunction

   // Mostly push-heavy or pop-heavy runs with reused keys, plus some noise
   function automatic sched_word_type random_word(input bit filling);
      sched_word_type s;
      int roll;
      s = '0;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         s.w.op = rqks_pkg::op_type'(2'($urandom_range(0, 3)));
      end else if (filling) begin
         if (roll < 58) s.w.op = rqks_pkg::OP_PUSH;
         else if (roll < 68) s.w.op = rqks_pkg::OP_POP;
         else if (roll < 78) s.w.op = rqks_pkg::OP_FRONT;
         else s.w.op = rqks_pkg::OP_SEARCH;
      end else begin
         if (roll < 23) s.w.op = rqks_pkg::OP_PUSH;
         else if (roll < 70) s.w.op = rqks_pkg::OP_POP;
         else if (roll < 80) s.w.op = rqks_pkg::OP_FRONT;
         else s.w.op = rqks_pkg::OP_SEARCH;
      end
      s.w.rec.key = random_key();
      s.w.rec.dest_key = random_key();
      s.w.rec.amount = $urandom;
      s.w.rec.kind = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (s.w.op == rqks_pkg::OP_PUSH) begin
         if (roll < 35) s.w.rec.key = hot_keys[$urandom_range(0, 7)];
         recent_keys.push_back(s.w.rec.key);
         if (recent_keys.size() > 8) recent_keys.delete(0);
      end else if (s.w.op == rqks_pkg::OP_SEARCH && recent_keys.size() != 0) begin
         if (roll < 55) s.w.rec.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
         else if (roll < 75) s.w.rec.key = hot_keys[$urandom_range(0, 7)];
      end
      return s;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want_v,
                                input logic [63:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("Mismatch in %s of result %0d: expected %0h, got %0h",
                     field, results_seen, want_v, got_v);
      end
   endtask

   // Wait until every scheduled word is taken and every result is back
   task automatic wait_quiet();
      while (word_backlog.size() != 0 || req_valid || pending_results.size() != 0)
         @(negedge clock);
   endtask

   // Write the capacity register while idle and mirror it in the model
   task automatic write_capacity(input logic [4:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cap_in_use = (value == 0) ? 1 : (value > DEPTH) ? DEPTH : int'(value);
      head_at = 0;
      tail_at = 0;
      held = 0;
      cap_writes++;
      @(negedge clock);
   endtask

   // Offer the next scheduled word; hold a stalled word unchanged
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // word taken at this edge: predict its result now
         if (req_valid) begin
            want = next_queue_result(in_flight.w);
            if (in_flight.pinned) want = in_flight.res;
            pending_results.push_back(want);
            n_op[in_flight.w.op]++;
            words_taken <= words_taken + 1;
         end
         if (word_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            in_flight = word_backlog.pop_front();
            req_opcode <= in_flight.w.op;
            req_key <= in_flight.w.rec.key;
            req_dest_key <= in_flight.w.rec.dest_key;
            req_amount <= in_flight.w.rec.amount;
            req_transaction_kind <= in_flight.w.rec.kind;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Check each result word against the oldest prediction; stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("Result %0d arrived with no word outstanding", results_seen);
            end else begin
               want = pending_results.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_status));
               compare_field("key", 64'(want.rec.key), 64'(rsp_out_key));
               compare_field("dest_key", 64'(want.rec.dest_key), 64'(rsp_out_dest_key));
               compare_field("amount", 64'(want.rec.amount), 64'(rsp_out_amount));
               compare_field("kind", 64'(want.rec.kind), 64'(rsp_out_kind));
               compare_field("count", 64'(want.count), 64'(rsp_count));
            end
            case (rsp_status)
               rqks_pkg::STAT_FULL: n_full++;
               rqks_pkg::STAT_EMPTY: n_empty++;
               rqks_pkg::STAT_NOT_FOUND: n_missed++;
               default: ;
            endcase
         end
         rsp_stall <= (backlog_left != 0) || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Hold off the result side once, long enough for the input to back up
   always @(posedge clock) begin
      if (reset) begin
         backlog_left <= 0;
         backlog_done <= 1'b0;
      end else if (!backlog_done && words_taken >= BACKLOG_AT) begin
         backlog_left <= BACKLOG_CYCLES;
         backlog_done <= 1'b1;
      end else if (backlog_left != 0) begin
         backlog_left <= backlog_left - 1;
      end
   end

   // Count cycles in which no word moves on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", stuck_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int i;
      int k;
      int mode_left;
      bit filling;
      logic [4:0] cap;
      sched_word_type item;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      hot_keys[0] = KMAX;
      hot_keys[1] = K0;
      for (i = 2; i < 8; i++) hot_keys[i] = random_key();

      // Walk the directed table
      for (i = 0; i < $size(directed_plan); i++) begin
         if (directed_plan[i].what == ROW_CAP) begin
            wait_quiet();
            write_capacity(directed_plan[i].cap);
         end else begin
            item = '0;
            item.w.op = directed_plan[i].op;
            item.w.rec = directed_plan[i].give;
            item.pinned = directed_plan[i].pinned;
            item.res.status = directed_plan[i].status;
            item.res.rec = directed_plan[i].take;
            item.res.count = directed_plan[i].count;
            word_backlog.push_back(item);
         end
      end
      wait_quiet();

      // Random phases, one capacity setting each
      filling = 1'b1;
      mode_left = $urandom_range(10, 40);
      for (i = 0; i < N_PHASES; i++) begin
         cap = (i < 8) ? phase_caps[i] : 5'($urandom_range(0, 31));
         write_capacity(cap);
         for (k = 0; k < WORDS_PER_PHASE; k++) begin
            if (mode_left == 0) begin
               filling = !filling;
               mode_left = $urandom_range(10, 40);
            end
            mode_left--;
            word_backlog.push_back(random_word(filling));
         end
         wait_quiet();
      end

      // Let any stray result surface
      repeat (DEPTH + 4) @(posedge clock);

      $display("Ran %0d words over %0d capacity writes: %0d push, %0d pop, %0d front, %0d search",
               words_taken, cap_writes, n_op[rqks_pkg::OP_PUSH], n_op[rqks_pkg::OP_POP],
               n_op[rqks_pkg::OP_FRONT], n_op[rqks_pkg::OP_SEARCH]);
      $display("Saw %0d full refusals, %0d empty replies, %0d missed searches, %0d mismatches",
               n_full, n_empty, n_missed, mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
